// ----- rtl/smooth_weighted_round_robin_defines.svh -----
// assertion macros for the checker file
// no dependencies
`ifndef SMOOTH_WEIGHTED_ROUND_ROBIN_DEFINES_SVH
`define SMOOTH_WEIGHTED_ROUND_ROBIN_DEFINES_SVH

// concurrent check, off while reset is asserted
`define SWRR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also holds during reset
`define SWRR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/swrr_pkg.sv -----
// types, constants and helpers for the smooth weighted round-robin selector
// no dependencies
`default_nettype none

package swrr_pkg;

	localparam int ENDPOINTS = 8;
	localparam int LANES     = 8;
	localparam int NLANE     = (ENDPOINTS < LANES) ? ENDPOINTS : LANES;
	localparam int LANE_W    = (NLANE > 1) ? $clog2(NLANE) : 1;

	localparam int MASK_W    = 8;
	localparam int EP_W      = 3;
	localparam int CNT_CFG_W = 4;
	localparam int WT_W      = 8;
	localparam int TABLE_W   = 64;
	localparam int RW_W      = 16;
	localparam int TOTAL_W   = WT_W + LANE_W;
	localparam int EXT_W     = RW_W + 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [CNT_CFG_W-1:0] N_ENDPOINTS_RST  = 4'd1;
	localparam logic [TABLE_W-1:0]   WEIGHT_TABLE_RST = 64'h0101_0101_0101_0101;
	localparam logic                 BREAKER_EN_RST   = 1'b0;

	localparam logic signed [RW_W-1:0] RW_MAX = 16'sh7fff;
	localparam logic signed [RW_W-1:0] RW_MIN = -16'sh8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_N_ENDPOINTS    = 2'd0,
		CFG_WEIGHT_TABLE   = 2'd1,
		CFG_BREAKER_ENABLE = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [CNT_CFG_W-1:0] n_endpoints;
		logic [TABLE_W-1:0]   weight_table;
		logic                 breaker_enable;
		logic                 clear;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} dp_sts_t;

	function automatic logic signed [RW_W-1:0] sat16(input logic signed [EXT_W-1:0] v);
		logic signed [EXT_W-1:0] hi;
		logic signed [EXT_W-1:0] lo;
		hi = EXT_W'(RW_MAX);
		lo = EXT_W'(RW_MIN);
		if (v > hi) begin
			return RW_MAX;
		end else if (v < lo) begin
			return RW_MIN;
		end else begin
			return v[RW_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// ----- rtl/swrr_if.sv -----
// valid/ready channel interfaces for request and response words
// depends on swrr_pkg
`default_nettype none

interface swrr_req_if import swrr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] inactive_mask;
	logic [MASK_W-1:0] breaker_open_mask;

	modport source (output valid, output inactive_mask, output breaker_open_mask, input ready);
	modport sink (input valid, input inactive_mask, input breaker_open_mask, output ready);
endinterface

interface swrr_rsp_if import swrr_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [EP_W-1:0] chosen_endpoint;
	logic            none_available;

	modport source (output valid, output chosen_endpoint, output none_available, input ready);
	modport sink (input valid, input chosen_endpoint, input none_available, output ready);
endinterface

`default_nettype wire

// ----- rtl/swrr_cfg.sv -----
// configuration registers and the running-weight clear strobe
// depends on swrr_pkg
`default_nettype none

module swrr_cfg import swrr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	logic [CNT_CFG_W-1:0] n_endpoints_q;
	logic [TABLE_W-1:0]   weight_table_q;
	logic                 breaker_enable_q;
	logic                 known;

	always_comb begin
		unique case (cfg_reg_t'(cfg_index))
			CFG_N_ENDPOINTS, CFG_WEIGHT_TABLE, CFG_BREAKER_ENABLE: known = 1'b1;
			default: known = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_endpoints_q    <= N_ENDPOINTS_RST;
			weight_table_q   <= WEIGHT_TABLE_RST;
			breaker_enable_q <= BREAKER_EN_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_N_ENDPOINTS:    n_endpoints_q    <= cfg_wdata[CNT_CFG_W-1:0];
				CFG_WEIGHT_TABLE:   weight_table_q   <= cfg_wdata[TABLE_W-1:0];
				CFG_BREAKER_ENABLE: breaker_enable_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg.n_endpoints    = n_endpoints_q;
	assign cfg.weight_table   = weight_table_q;
	assign cfg.breaker_enable = breaker_enable_q;
	// any write to a listed register drops the running weights
	assign cfg.clear          = cfg_we & known;

endmodule

`default_nettype wire

// ----- rtl/swrr_ctrl.sv -----
// sequencer: accept, eight-lane scan, finish and hand off the result word
// depends on swrr_pkg
`default_nettype none

module swrr_ctrl import swrr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// wait here until the output register can take the word
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/swrr_dp.sv -----
// datapath: running weights, lane scan with max tracking, winner update, output register
// depends on swrr_pkg
`default_nettype none

module swrr_dp import swrr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	input  logic [MASK_W-1:0] inactive_mask,
	input  logic [MASK_W-1:0] breaker_open_mask,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [EP_W-1:0]   rsp_chosen,
	output logic              rsp_none
);

	logic signed [RW_W-1:0] rw_q [NLANE];
	logic [NLANE-1:0]       elig_q;
	logic [LANE_W-1:0]      idx_q;
	logic [LANE_W-1:0]      chosen_q;
	logic signed [RW_W-1:0] best_q;
	logic [TOTAL_W-1:0]     total_q;
	logic                   found_q;
	logic                   out_valid_q;
	logic [EP_W-1:0]        out_chosen_q;
	logic                   out_none_q;

	logic [NLANE-1:0]       elig_d;
	logic [LANE_W-1:0]      rd_addr;
	logic signed [RW_W-1:0] rd_val;
	logic [WT_W-1:0]        wt_raw;
	logic [WT_W-1:0]        wt;
	logic signed [RW_W-1:0] add_sat;
	logic signed [RW_W-1:0] sub_sat;
	logic                   take;

	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			elig_d[i] = (int'(cfg.n_endpoints) > i) & ~inactive_mask[i]
				& ~(cfg.breaker_enable & breaker_open_mask[i]);
		end
	end

	// one read port: scan lane while scanning, winner while finishing
	assign rd_addr = cmd.finish ? chosen_q : idx_q;
	assign rd_val  = rw_q[rd_addr];

	assign wt_raw = cfg.weight_table[WT_W*idx_q +: WT_W];
	assign wt     = (wt_raw == '0) ? WT_W'(1) : wt_raw;

	assign add_sat = sat16(EXT_W'(rd_val) + $signed({{(EXT_W-WT_W){1'b0}}, wt}));
	assign sub_sat = sat16(EXT_W'(rd_val) - $signed({{(EXT_W-TOTAL_W){1'b0}}, total_q}));

	assign take = cmd.step & elig_q[idx_q];

	assign sts.scan_last = (idx_q == LANE_W'(NLANE - 1));
	assign sts.out_free  = ~out_valid_q | rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NLANE; i++) begin
				rw_q[i] <= '0;
			end
			idx_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.clear) begin
				for (int i = 0; i < NLANE; i++) begin
					rw_q[i] <= '0;
				end
			end else if (take) begin
				rw_q[idx_q] <= add_sat;
			end else if (cmd.finish && found_q) begin
				rw_q[chosen_q] <= sub_sat;
			end

			if (cmd.load) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.step) begin
				idx_q <= idx_q + LANE_W'(1);
				if (take) begin
					found_q <= 1'b1;
				end
			end

			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			elig_q   <= elig_d;
			chosen_q <= '0;
			total_q  <= '0;
			best_q   <= '0;
		end else if (take) begin
			total_q <= total_q + TOTAL_W'(wt);
			// strict compare keeps the lowest index on a tie
			if (!found_q || add_sat > best_q) begin
				best_q   <= add_sat;
				chosen_q <= idx_q;
			end
		end
		if (cmd.finish) begin
			out_chosen_q <= EP_W'(chosen_q);
			out_none_q   <= ~found_q;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign rsp_chosen = out_chosen_q;
	assign rsp_none   = out_none_q;

endmodule

`default_nettype wire

// ----- rtl/smooth_weighted_round_robin.sv -----
// one request word in, one response word out; each word takes accept, eight
// scan steps over the lanes through the single running-weight read port, finish
// response is registered at the finish step and held valid; next accept the cycle after
// the finish step stalls only while the previous response still sits unread
// reset loads the register defaults and zeroes all running weights
// a configuration write to a listed register also zeroes the running weights
`default_nettype none

module smooth_weighted_round_robin import swrr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	swrr_req_if.sink              req,
	swrr_rsp_if.source            rsp
);

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;

	swrr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	swrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	swrr_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.cmd               (cmd),
		.sts               (sts),
		.inactive_mask     (req.inactive_mask),
		.breaker_open_mask (req.breaker_open_mask),
		.rsp_valid         (rsp.valid),
		.rsp_ready         (rsp.ready),
		.rsp_chosen        (rsp.chosen_endpoint),
		.rsp_none          (rsp.none_available)
	);

endmodule

`default_nettype wire

// ----- rtl/swrr_checker.sv -----
// port-level checks for the selector, bound to the top level
// depends on swrr_pkg and smooth_weighted_round_robin_defines.svh
`default_nettype none
`include "smooth_weighted_round_robin_defines.svh"

module swrr_checker import swrr_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input logic [EP_W-1:0] rsp_chosen,
	input logic            rsp_none
);

	`SWRR_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_chosen) && $stable(rsp_none), "response word dropped or changed while stalled")
	`SWRR_ASSERT(a_none_zero, clk, arst_n, rsp_valid && rsp_none |-> rsp_chosen == '0, "no-endpoint response carries a nonzero index")
	`SWRR_ASSERT(a_one_in_flight, clk, arst_n, req_valid && req_ready |=> !req_ready, "request taken while a selection is in progress")
	`SWRR_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !rsp_valid, "response valid during reset")

endmodule

bind smooth_weighted_round_robin swrr_checker u_swrr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_chosen (rsp.chosen_endpoint),
	.rsp_none   (rsp.none_available)
);

`default_nettype wire

// ----- tb/swrr_tb_pkg.sv -----
// scoreboard for the smooth weighted round-robin selector: predicts each pick
// and checks response words in order; depends on swrr_pkg
`timescale 1ns / 100ps

package swrr_tb_pkg;
	import swrr_pkg::*;

	typedef struct {
		logic [EP_W-1:0] endpoint;
		logic            none;
	} pick_t;

	class swrr_scoreboard;
		logic [CNT_CFG_W-1:0]     n_endpoints;
		logic [TABLE_W-1:0]       weight_table;
		logic                     breaker_enable;
		logic signed [RW_W-1:0]   running_wt [NLANE];
		pick_t                    picks_due [$];
		int                       mismatches;
		int                       requests;
		int                       empty_picks;
		int                       sat_hits;
		int                       settings;

		function new();
			n_endpoints    = N_ENDPOINTS_RST;
			weight_table   = WEIGHT_TABLE_RST;
			breaker_enable = BREAKER_EN_RST;
			clear_weights();
		endfunction

		function void clear_weights();
			foreach (running_wt[i])
				running_wt[i] = '0;
		endfunction

		function logic signed [RW_W-1:0] clamp(int v);
			if (v > int'(RW_MAX)) begin
				sat_hits++;
				return RW_MAX;
			end
			if (v < int'(RW_MIN)) begin
				sat_hits++;
				return RW_MIN;
			end
			return v[RW_W-1:0];
		endfunction

		function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_N_ENDPOINTS: n_endpoints = data[CNT_CFG_W-1:0];
				CFG_WEIGHT_TABLE: weight_table = data[TABLE_W-1:0];
				CFG_BREAKER_ENABLE: breaker_enable = data[0];
				default: return;
			endcase
			settings++;
			clear_weights();
		endfunction

		// accepted request word: work out the pick and queue it
		function void note_request(logic [MASK_W-1:0] inactive, logic [MASK_W-1:0] brk);
			int    limit;
			int    total;
			int    chosen;
			int    wt;
			logic  [MASK_W-1:0] eligible;
			pick_t p;
			requests++;
			limit = (int'(n_endpoints) > NLANE) ? NLANE : int'(n_endpoints);
			eligible = '0;
			for (int i = 0; i < limit; i++)
				eligible[i] = !inactive[i] && !(breaker_enable && brk[i]);
			if (eligible == '0) begin
				empty_picks++;
				p.endpoint = '0;
				p.none     = 1'b1;
				picks_due.push_back(p);
				return;
			end
			total  = 0;
			chosen = -1;
			for (int i = 0; i < limit; i++) begin
				if (eligible[i]) begin
					wt = int'(weight_table[WT_W*i +: WT_W]);
					if (wt == 0)
						wt = 1;
					running_wt[i] = clamp(int'(running_wt[i]) + wt);
					total += wt;
					// strict compare keeps the lowest index on a tie
					if (chosen < 0 || running_wt[i] > running_wt[chosen])
						chosen = i;
				end
			end
			running_wt[chosen] = clamp(int'(running_wt[chosen]) - total);
			p.endpoint = chosen[EP_W-1:0];
			p.none     = 1'b0;
			picks_due.push_back(p);
		endfunction

		function void check_response(logic [EP_W-1:0] endpoint, logic none);
			pick_t p;
			if (picks_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: response word ep=%0d none=%0b with no request outstanding",
						$realtime, endpoint, none);
				return;
			end
			p = picks_due.pop_front();
			if (endpoint !== p.endpoint || none !== p.none) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch: expected ep=%0d none=%0b, got ep=%0d none=%0b",
						$realtime, p.endpoint, p.none, endpoint, none);
			end
		endfunction

		function int pending();
			return picks_due.size();
		endfunction
	endclass

endpackage

// ----- tb/tb_top.sv -----
// top-level testbench for smooth_weighted_round_robin: directed and random
// request words under several register settings; depends on swrr_pkg, swrr_if, swrr_tb_pkg
`timescale 1ns / 100ps

module tb_top;
	import swrr_pkg::*;
	import swrr_tb_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
	localparam int PHASES     = 12;
	localparam int PHASE_REQS = 140;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	bit                    no_stall;
	swrr_scoreboard        sb;

	swrr_req_if req_ch ();
	swrr_rsp_if rsp_ch ();

	smooth_weighted_round_robin dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("timeout with %0d responses outstanding", sb.pending());
		$display("** smooth_weighted_round_robin: FAILED **");
		$finish;
	end

	// word monitors
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.inactive_mask, req_ch.breaker_open_mask);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response(rsp_ch.chosen_endpoint, rsp_ch.none_available);
		end
	end

	// response side back-pressure
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= arst_n && (no_stall || $urandom_range(99) >= 17);
		end
	end

	function automatic logic [MASK_W-1:0] random_mask();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return MASK_W'($urandom);
			default: return MASK_W'($urandom & $urandom & $urandom);
		endcase
	endfunction

	function automatic logic [TABLE_W-1:0] random_table();
		logic [TABLE_W-1:0] t;
		for (int i = 0; i < TABLE_W / WT_W; i++) begin
			case ($urandom_range(5))
				0: t[WT_W*i +: WT_W] = 8'h00;
				1: t[WT_W*i +: WT_W] = 8'hff;
				2: t[WT_W*i +: WT_W] = 8'h01;
				default: t[WT_W*i +: WT_W] = WT_W'($urandom_range(255));
			endcase
		end
		return t;
	endfunction

	task automatic send_request(logic [MASK_W-1:0] inactive, logic [MASK_W-1:0] brk);
		@(negedge clk);
		while (!no_stall && $urandom_range(99) < 17) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid             <= 1'b1;
		req_ch.inactive_mask     <= inactive;
		req_ch.breaker_open_mask <= brk;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	task automatic drop_request();
		@(negedge clk);
		req_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.apply_config(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(logic [CNT_CFG_W-1:0] n, logic [TABLE_W-1:0] tbl, logic brk_en);
		drop_request();
		wait_drained();
		write_reg(CFG_WEIGHT_TABLE, CFG_DATA_W'(tbl));
		write_reg(CFG_BREAKER_ENABLE, CFG_DATA_W'(brk_en));
		write_reg(CFG_N_ENDPOINTS, CFG_DATA_W'(n));
	endtask

	task automatic run_phase(int count, bit drain_midway);
		for (int k = 0; k < count; k++) begin
			if (drain_midway && k == count / 2) begin
				drop_request();
				wait_drained();
			end
			send_request(random_mask(), random_mask());
		end
	endtask

	initial begin
		logic [CNT_CFG_W-1:0] n;
		sb                       = new();
		arst_n                   = 1'b0;
		cfg_we                   = 1'b0;
		cfg_index                = CFG_N_ENDPOINTS;
		cfg_wdata                = '0;
		no_stall                 = 1'b0;
		req_ch.valid             = 1'b0;
		req_ch.inactive_mask     = '0;
		req_ch.breaker_open_mask = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset defaults: one endpoint, breaker check off
		send_request(8'h00, 8'h00);
		send_request(8'hff, 8'h00);
		send_request(8'hfe, 8'hff);

		// all eight endpoints, mixed weights, breaker check on
		configure(4'd8, 64'hff00_0102_0380_7f01, 1'b1);
		send_request(8'h00, 8'h00);
		send_request(8'h00, 8'h00);
		send_request(8'h00, 8'hff);
		send_request(8'hff, 8'h00);
		send_request(8'haa, 8'h55);
		send_request(8'h55, 8'h00);
		send_request(8'h00, 8'haa);
		send_request(8'h7f, 8'h00);
		send_request(8'hfe, 8'h00);
		// a write to the spare index must leave running weights alone
		drop_request();
		wait_drained();
		write_reg(CFG_SPARE_IDX, '1);
		send_request(8'h00, 8'h00);
		send_request(8'h00, 8'h00);

		// count above eight, all weights zero so every lane counts 1: ties
		configure(4'hf, 64'h0, 1'b0);
		repeat (4) send_request(8'h00, 8'hff);
		send_request(8'h01, 8'h00);

		// no endpoints in use
		configure(4'd0, 64'hffff_ffff_ffff_ffff, 1'b0);
		send_request(8'h00, 8'h00);
		send_request(8'hff, 8'hff);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: configure(4'd8, '1, 1'b1);
				1: configure(4'd8, 64'h0, 1'b0);
				2: configure(4'd9, random_table(), 1'b1);
				3: configure(4'd1, random_table(), 1'b0);
				default: begin
					case ($urandom_range(9))
						0: n = 4'd0;
						1: n = CNT_CFG_W'($urandom_range(9, 15));
						default: n = CNT_CFG_W'($urandom_range(1, 8));
					endcase
					configure(n, random_table(), 1'($urandom));
					if ($urandom_range(3) == 0)
						write_reg(CFG_SPARE_IDX, CFG_DATA_W'({$urandom, $urandom}));
				end
			endcase
			// one phase runs with neither side stalling
			no_stall = (p == 2);
			run_phase(PHASE_REQS, p == 5);
		end
		no_stall = 1'b0;

		drop_request();
		wait_drained();
		repeat (24) @(posedge clk);

		if (sb.pending() != 0)
			$display("%0d responses never arrived", sb.pending());
		$display("covered %0d requests, %0d with no eligible endpoint, over %0d register writes",
			sb.requests, sb.empty_picks, sb.settings);
		$display("saturating updates: %0d, mismatches: %0d", sb.sat_hits, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("** smooth_weighted_round_robin: PASSED **");
		end else begin
			$display("** smooth_weighted_round_robin: FAILED **");
		end
		$finish;
	end

endmodule
